// ===== hw/rtl/ycde_pkg.sv =====
// Package for the yield curve discount engine: payload structs, request codes,
// status codes and arithmetic constants. No dependencies.
package ycde_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int TIME_FRAC      = 24;
	localparam int EXP_TERMS      = 17;
	localparam logic [63:0] LN2_Q58 = 64'hB17217F7D1CF79AB >> 6;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_SPOT  = 2'd1,
		REQ_FWD   = 2'd2,
		REQ_SHORT = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_BEYOND = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         point_index;
		logic [30:0]        time_a;
		logic [30:0]        time_b;
		logic signed [31:0] rate_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_WRD,
		S_WALK,
		S_NEXTT,
		S_RED,
		S_EXPM,
		S_EXPD,
		S_DIV,
		S_OUT
	} fsm_t;

endpackage

// ===== hw/rtl/ycde_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module ycde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/ycde_mul.sv =====
// Sequential 64x64 unsigned multiplier using one 32x32 product per cycle,
// returning the low 64 bits of floor(a*b/2^60). Depends on nothing.
module ycde_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] q
);
	logic [2:0]   step_q;
	logic         run_q;
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  prod;
	logic [127:0] sh;

	always_comb begin
		pa = step_q[1] ? a_q[63:32] : a_q[31:0];
		pb = step_q[0] ? b_q[63:32] : b_q[31:0];
		prod = 64'(pa) * 64'(pb);
		case (step_q[1:0])
			2'd0:    sh = 128'(prod);
			2'd3:    sh = {prod, 64'd0};
			default: sh = {32'd0, prod, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + sh;
		end
	end

	assign q = acc_q[123:60];
endmodule

// ===== hw/rtl/ycde_div.sv =====
// Divider of a value below 2^61 by a term number from 1 to EXP_TERMS, done as a
// multiply by a rounded-up reciprocal. Depends on ycde_pkg and ycde_mul.
module ycde_div
	import ycde_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] num,
	input  logic [4:0]  den,
	output logic        done,
	output logic [63:0] q
);
	logic [63:0] recip [32];
	logic [2:0]  rshift [32];
	logic [4:0]  den_q;
	logic [63:0] prod;

	// ceil(2^(61+l)/n) with l = clog2(n). The rounding error stays below 1/n for
	// every dividend under 2^61, so the shifted product is the exact floor.
	function automatic logic [63:0] recip_const(input int n);
		logic [127:0] scaled;
		scaled = 128'd1 << (61 + $clog2(n));
		return 64'((scaled + 128'(n - 1)) / 128'(n));
	endfunction

	for (genvar g = 0; g < 32; g++) begin : g_recip
		if (g >= 1 && g <= EXP_TERMS) begin : g_used
			localparam logic [63:0] RC = recip_const(g);
			assign recip[g]  = RC;
			assign rshift[g] = 3'(1 + $clog2(g));
		end else begin : g_unused
			assign recip[g]  = '0;
			assign rshift[g] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den;
		end
	end

	ycde_mul u_mul (.clk(clk), .arst_n(arst_n), .go(go), .a(num), .b(recip[den]),
		.done(done), .q(prod));

	assign q = prod >> rshift[den_q];
endmodule

// ===== hw/rtl/yield_curve_discount_engine_unit.sv =====
// Top level of the yield curve discount engine: APB register, curve memories,
// segment walk and exponential sequencer. Uses ycde_pkg, ycde_ram, ycde_mul, ycde_div.
//
// Usage. A request beat is taken at a rising edge with start high and busy
// low; busy stays high until the result beat. Loads write a curve point (end
// time, rate) into two synchronous RAMs. Queries walk the stored segments from
// point 0, each segment in a RAM read state and then an accumulate state,
// integrating the rate curve exactly in 64 bits. Spot and forward answers then
// reduce the exponent by ln2, one subtraction or addition per cycle, and run a
// 17-term Horner series; each term is a multiply followed by a divide by the
// term number (a multiply by its reciprocal). An exponent out of range
// saturates the answer instead. A forward query adds a second walk, with the
// S_NEXTT state between the walks. At most MAX_POINTS (64 by default)
// segments are visited per walk. The result beat shows for one cycle with done
// high; the receiver cannot stall it. point_count is written over APB at
// address 0; the user must write it only while idle, as the block itself does
// not enforce this. Reset clears the control state and sets point_count to
// one; the curve memories are undefined until loaded.
module yield_curve_discount_engine_unit
	import ycde_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int YF = FRAC_BITS + TIME_FRAC;
	localparam logic signed [63:0] Y_HI = 64'sd16 <<< YF;
	localparam logic signed [63:0] Y_LO = -(64'sd23 <<< YF);
	localparam logic [63:0] ONE60 = 64'd1 << 60;

	fsm_t state_q, state_d;

	logic [6:0]  pcnt_q;
	logic [6:0]  nused;
	logic        wr_apb;

	req_t        req_q;
	logic [AW:0] idx_q;
	logic [30:0] prev_q;
	logic signed [63:0] acc_q, ia_q;
	logic        second_q;
	logic        started_q;
	logic        mul_busy_q;
	logic signed [63:0] f_q;
	logic signed [7:0]  k_q;
	logic [4:0]  n_q;
	logic [63:0] s_q;
	logic signed [31:0] res_q;
	logic [1:0]  stat_q;

	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [30:0] t_rd;
	logic [31:0] r_rd;
	logic [30:0] tq, seg_end;
	logic signed [63:0] seg_int;
	logic        last_seg, hit;

	logic        mul_go, mul_done, div_go, div_done;
	logic [63:0] mul_q, div_q;
	logic signed [63:0] y;
	logic [6:0]  sh;
	logic [63:0] rnd;

	assign pready = 1'b1;
	assign wr_apb = psel && penable && pwrite && (paddr == 1'b0);
	assign prdata = (paddr == 1'b0) ? {25'd0, pcnt_q} : 32'd0;

	always_comb begin
		if (pcnt_q == 7'd0) nused = 7'd1;
		else if (32'(pcnt_q) > MAX_POINTS) nused = 7'(MAX_POINTS);
		else nused = pcnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pcnt_q <= 7'd1;
		else if (wr_apb) pcnt_q <= pwdata[6:0];
	end

	assign ram_we   = (state_q == S_LOAD) && (32'(req_q.point_index) < MAX_POINTS);
	assign ram_addr = (state_q == S_LOAD) ? AW'(req_q.point_index) : idx_q[AW-1:0];

	ycde_ram #(.WIDTH(31), .DEPTH(MAX_POINTS)) u_times (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req_q.time_a), .rdata(t_rd));
	ycde_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_rates (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req_q.rate_value), .rdata(r_rd));

	// Walk datapath: one segment product per visit.
	always_comb begin
		tq       = second_q ? req_q.time_b : req_q.time_a;
		seg_end  = (t_rd > prev_q) ? t_rd : prev_q;
		last_seg = (32'(idx_q) + 1 >= 32'(nused));
		hit      = (tq <= seg_end);
		seg_int  = 64'($signed(r_rd)) * $signed({33'd0, ((hit || last_seg) ? tq : seg_end) - prev_q});
	end

	// The exponent: -I(T) for a spot query, I(start) - I(end) for a forward one.
	// acc_q holds the last walk's integral while the reduction runs.
	assign y = (req_q.req_type == REQ_SPOT) ? -acc_q : (ia_q - acc_q);

	// One multiply per Horner term, launched on the first cycle in S_EXPM; the
	// divide by the term number starts as soon as the product is ready.
	assign mul_go = (state_q == S_EXPM) && !mul_busy_q;
	assign div_go = (state_q == S_EXPM) && mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_busy_q <= 1'b0;
		else if (mul_go) mul_busy_q <= 1'b1;
		else if (mul_done) mul_busy_q <= 1'b0;
	end

	ycde_mul u_mul (.clk(clk), .arst_n(arst_n), .go(mul_go),
		.a(s_q), .b({f_q[61:0], 2'b00}), .done(mul_done), .q(mul_q));
	ycde_div u_div (.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(mul_q), .den(n_q), .done(div_done), .q(div_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = (req.req_type == REQ_LOAD) ? S_LOAD : S_WRD;
			S_LOAD:  state_d = S_OUT;
			S_WRD:   state_d = S_WALK;
			S_WALK: begin
				if (hit || last_seg) begin
					if (req_q.req_type == REQ_FWD && !second_q) state_d = S_NEXTT;
					else if (req_q.req_type == REQ_SHORT) state_d = S_OUT;
					else state_d = S_RED;
				end else begin
					state_d = S_WRD;
				end
			end
			S_NEXTT: state_d = S_WRD;
			S_RED: begin
				if (y >= Y_HI || y < Y_LO) state_d = S_OUT;
				else if (started_q && f_q >= 0 && f_q < $signed(LN2_Q58)) state_d = S_EXPM;
			end
			S_EXPM:  if (mul_done) state_d = S_DIV;
			S_DIV:   if (div_done) state_d = (n_q == 5'd1) ? S_EXPD : S_EXPM;
			S_EXPD:  state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
		done = (state_q == S_OUT);
		result.result_value = res_q;
		result.status       = stat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		sh  = 7'(60 - FRAC_BITS) - 7'(k_q);
		rnd = s_q + (64'd1 << (sh - 7'd1));
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q     <= req;
				idx_q     <= '0;
				prev_q    <= '0;
				acc_q     <= '0;
				second_q  <= 1'b0;
				started_q <= 1'b0;
				res_q     <= '0;
				stat_q    <= ST_OK;
			end
			S_LOAD: if (!(32'(req_q.point_index) < MAX_POINTS)) stat_q <= ST_BAD;
			S_WALK: begin
				if (hit || last_seg) begin
					if (!hit) stat_q <= ST_BEYOND;
					res_q   <= r_rd;
					if (second_q || req_q.req_type != REQ_FWD) acc_q <= acc_q + seg_int;
					else ia_q <= acc_q + seg_int;
				end else begin
					acc_q  <= acc_q + seg_int;
					prev_q <= seg_end;
					idx_q  <= idx_q + 1'b1;
				end
			end
			S_NEXTT: begin
				second_q <= 1'b1;
				idx_q    <= '0;
				prev_q   <= '0;
				acc_q    <= '0;
			end
			S_RED: begin
				if (req_q.req_type == REQ_SPOT && !started_q) ia_q <= acc_q;
				if (!started_q) begin
					started_q <= 1'b1;
					f_q <= (req_q.req_type == REQ_SPOT ? -acc_q : (ia_q - acc_q))
						<<< (34 - FRAC_BITS);
					k_q <= '0;
				end else if (f_q >= $signed(LN2_Q58)) begin
					f_q <= f_q - $signed(LN2_Q58);
					k_q <= k_q + 8'sd1;
				end else if (f_q < 0) begin
					f_q <= f_q + $signed(LN2_Q58);
					k_q <= k_q - 8'sd1;
				end
				n_q <= 5'(EXP_TERMS);
				s_q <= ONE60;
				if (y >= Y_HI) res_q <= 32'h7FFFFFFF;
				if (y < Y_LO) res_q <= '0;
			end
			S_DIV: if (div_done) begin
				s_q <= ONE60 + div_q;
				n_q <= n_q - 5'd1;
			end
			S_EXPD: begin
				if ($signed({1'b0, sh}) <= 0) res_q <= 32'h7FFFFFFF;
				else if (sh >= 7'd64) res_q <= '0;
				else if ((rnd >> sh) > 64'h7FFFFFFF) res_q <= 32'h7FFFFFFF;
				else res_q <= 32'(rnd >> sh);
			end
			default: ;
		endcase
	end
endmodule
